FILE: hdl/ptk_pkg.sv
// Shared types and constants for the parent keyed table.
package ptk_pkg;

    localparam int CAPACITY = 64;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = ADDR_W + 1;
    localparam int KEY_W    = 32;
    localparam int INFO_W   = 32;

    localparam logic [2:0] OP_INSERT  = 3'd0;
    localparam logic [2:0] OP_DELETE  = 3'd1;
    localparam logic [2:0] OP_CASCADE = 3'd2;
    localparam logic [2:0] OP_FIND    = 3'd3;
    localparam logic [2:0] OP_LIST    = 3'd4;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_DUP      = 3'd1;
    localparam logic [2:0] ST_NOPAR    = 3'd2;
    localparam logic [2:0] ST_NOTFOUND = 3'd3;
    localparam logic [2:0] ST_FULL     = 3'd4;

    typedef struct packed {
        logic [2:0]        operation;
        logic [KEY_W-1:0]  item_key;
        logic [KEY_W-1:0]  parent_key;
        logic [INFO_W-1:0] info_word;
    } cmd_t;

    typedef struct packed {
        logic [2:0]        status;
        logic [KEY_W-1:0]  found_key;
        logic [KEY_W-1:0]  found_parent;
        logic [INFO_W-1:0] found_info;
        logic              last;
    } res_t;

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [KEY_W-1:0]  parent;
        logic [INFO_W-1:0] info;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_EV,
        S_SRCH,
        S_SRC_RD,
        S_SRC_LD,
        S_CMP_RD,
        S_CMP_EV,
        S_LST_RD,
        S_LST_EV
    } state_t;

endpackage

FILE: hdl/parent_keyed_table.sv
// Insert, delete and list each sweep the N stored entries once; find stops at the first match.
// Cascade delete runs one parent-match sweep for the key and one per doomed entry, then a compaction sweep.
// One command at a time; each entry visit passes through a read state and an evaluate state on the RAM.
// Result words show for one cycle on valid, the receiver cannot stall; list gives a word per child.
// Reset empties the table at once; entry storage is not cleared.
module parent_keyed_table (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  ptk_pkg::cmd_t cmd,
    output logic          valid,
    output ptk_pkg::res_t result
);
    import ptk_pkg::*;

    state_t state_reg, state_next;
    cmd_t   cmd_reg, cmd_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0] wr_reg, wr_next;
    logic [KEY_W-1:0] src_reg, src_next;
    logic [CAPACITY-1:0] marks_reg, marks_next;
    logic [CAPACITY-1:0] done_reg, done_next;
    logic dup_reg, dup_next;
    logic parok_reg, parok_next;
    logic removed_reg, removed_next;
    logic pend_reg, pend_next;
    entry_t pend_ent_reg, pend_ent_next;
    logic valid_reg, valid_next;
    res_t res_reg, res_next;

    logic             we;
    logic [ADDR_W-1:0] waddr;
    entry_t           wdata;
    logic [ADDR_W-1:0] raddr;
    entry_t           rdata;
    logic [CNT_W-1:0] idx_m1;
    logic [ADDR_W-1:0] ia;

    ptk_ram #(.WIDTH(ENTRY_W), .DEPTH(CAPACITY)) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign idx_m1 = idx_reg - CNT_W'(1);
    assign ia     = idx_reg[ADDR_W-1:0];
    assign busy   = (state_reg != S_IDLE);
    assign valid  = valid_reg;
    assign result = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            marks_reg <= '0;
            done_reg  <= '0;
            valid_reg <= 1'b0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            marks_reg <= marks_next;
            done_reg  <= done_next;
            valid_reg <= valid_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        idx_reg      <= idx_next;
        wr_reg       <= wr_next;
        src_reg      <= src_next;
        dup_reg      <= dup_next;
        parok_reg    <= parok_next;
        removed_reg  <= removed_next;
        pend_ent_reg <= pend_ent_next;
        res_reg      <= res_next;
    end

    always_comb
    begin
        state_next    = state_reg;
        cmd_next      = cmd_reg;
        count_next    = count_reg;
        idx_next      = idx_reg;
        wr_next       = wr_reg;
        src_next      = src_reg;
        marks_next    = marks_reg;
        done_next     = done_reg;
        dup_next      = dup_reg;
        parok_next    = parok_reg;
        removed_next  = removed_reg;
        pend_next     = pend_reg;
        pend_ent_next = pend_ent_reg;
        valid_next    = 1'b0;
        res_next      = res_reg;
        we            = 1'b0;
        waddr         = wr_reg[ADDR_W-1:0];
        wdata         = rdata;
        raddr         = ia;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd_next     = cmd;
                    idx_next     = '0;
                    wr_next      = '0;
                    src_next     = cmd.item_key;
                    dup_next     = 1'b0;
                    parok_next   = 1'b0;
                    removed_next = 1'b0;
                    pend_next    = 1'b0;
                    if (cmd.operation == OP_INSERT || cmd.operation == OP_FIND
                        || cmd.operation == OP_CASCADE)
                    begin
                        state_next = S_SCAN_RD;
                    end
                    else if (cmd.operation == OP_DELETE)
                    begin
                        state_next = S_CMP_RD;
                    end
                    else if (cmd.operation == OP_LIST)
                    begin
                        idx_next   = count_reg;
                        state_next = S_LST_RD;
                    end
                end
            end

            S_SCAN_RD:
            begin
                if (idx_reg == count_reg)
                begin
                    res_next = '{status: ST_OK, found_key: '0, found_parent: '0,
                                 found_info: '0, last: 1'b1};
                    if (cmd_reg.operation == OP_CASCADE)
                    begin
                        idx_next   = '0;
                        state_next = S_SRCH;
                    end
                    else if (cmd_reg.operation == OP_FIND)
                    begin
                        res_next.status = ST_NOTFOUND;
                        valid_next      = 1'b1;
                        state_next      = S_IDLE;
                    end
                    else
                    begin
                        // insert: checks in order duplicate, parent, room
                        valid_next = 1'b1;
                        state_next = S_IDLE;
                        if (dup_reg)
                        begin
                            res_next.status = ST_DUP;
                        end
                        else if (cmd_reg.parent_key != '0
                                 && cmd_reg.parent_key != cmd_reg.item_key && !parok_reg)
                        begin
                            res_next.status = ST_NOPAR;
                        end
                        else if (count_reg == CNT_W'(CAPACITY))
                        begin
                            res_next.status = ST_FULL;
                        end
                        else
                        begin
                            we         = 1'b1;
                            waddr      = count_reg[ADDR_W-1:0];
                            wdata      = '{key: cmd_reg.item_key, parent: cmd_reg.parent_key,
                                           info: cmd_reg.info_word};
                            count_next = count_reg + CNT_W'(1);
                        end
                    end
                end
                else
                begin
                    state_next = S_SCAN_EV;
                end
            end

            S_SCAN_EV:
            begin
                idx_next   = idx_reg + CNT_W'(1);
                state_next = S_SCAN_RD;
                if (cmd_reg.operation == OP_INSERT)
                begin
                    dup_next   = dup_reg | (rdata.key == cmd_reg.item_key);
                    parok_next = parok_reg | (rdata.key == cmd_reg.parent_key);
                end
                else if (cmd_reg.operation == OP_FIND)
                begin
                    if (rdata.key == cmd_reg.item_key)
                    begin
                        res_next   = '{status: ST_OK, found_key: rdata.key,
                                       found_parent: rdata.parent, found_info: rdata.info,
                                       last: 1'b1};
                        valid_next = 1'b1;
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    // self-parented entries never join the cascade
                    if (!marks_reg[ia] && rdata.parent != rdata.key
                        && rdata.parent == src_reg)
                    begin
                        marks_next[ia] = 1'b1;
                    end
                end
            end

            S_SRCH:
            begin
                if (idx_reg == count_reg)
                begin
                    idx_next   = '0;
                    wr_next    = '0;
                    state_next = S_CMP_RD;
                end
                else if (marks_reg[ia] && !done_reg[ia])
                begin
                    done_next[ia] = 1'b1;
                    state_next    = S_SRC_RD;
                end
                else
                begin
                    idx_next = idx_reg + CNT_W'(1);
                end
            end

            S_SRC_RD:
            begin
                state_next = S_SRC_LD;
            end

            S_SRC_LD:
            begin
                src_next   = rdata.key;
                idx_next   = '0;
                state_next = S_SCAN_RD;
            end

            S_CMP_RD:
            begin
                if (idx_reg == count_reg)
                begin
                    count_next = wr_reg;
                    marks_next = '0;
                    done_next  = '0;
                    res_next   = '{status: ST_OK, found_key: '0, found_parent: '0,
                                   found_info: '0, last: 1'b1};
                    if (cmd_reg.operation == OP_DELETE && !removed_reg)
                    begin
                        res_next.status = ST_NOTFOUND;
                    end
                    valid_next = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_CMP_EV;
                end
            end

            S_CMP_EV:
            begin
                idx_next   = idx_reg + CNT_W'(1);
                state_next = S_CMP_RD;
                if (marks_reg[ia] || rdata.key == cmd_reg.item_key)
                begin
                    removed_next = 1'b1;
                end
                else
                begin
                    we      = 1'b1;
                    wr_next = wr_reg + CNT_W'(1);
                end
            end

            S_LST_RD:
            begin
                raddr = idx_m1[ADDR_W-1:0];
                if (idx_reg == '0)
                begin
                    valid_next = 1'b1;
                    state_next = S_IDLE;
                    if (pend_reg)
                    begin
                        res_next = '{status: ST_OK, found_key: pend_ent_reg.key,
                                     found_parent: pend_ent_reg.parent,
                                     found_info: pend_ent_reg.info, last: 1'b1};
                    end
                    else
                    begin
                        res_next = '{status: ST_NOTFOUND, found_key: '0, found_parent: '0,
                                     found_info: '0, last: 1'b1};
                    end
                    pend_next = 1'b0;
                end
                else
                begin
                    state_next = S_LST_EV;
                end
            end

            S_LST_EV:
            begin
                idx_next   = idx_m1;
                state_next = S_LST_RD;
                if (rdata.parent == cmd_reg.parent_key)
                begin
                    // hold each child one step so the final word can carry last
                    if (pend_reg)
                    begin
                        res_next   = '{status: ST_OK, found_key: pend_ent_reg.key,
                                       found_parent: pend_ent_reg.parent,
                                       found_info: pend_ent_reg.info, last: 1'b0};
                        valid_next = 1'b1;
                    end
                    pend_next     = 1'b1;
                    pend_ent_next = rdata;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count beyond capacity");

    a_idle_last: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && state_reg == S_IDLE |-> res_reg.last)
        else $error("word shown while idle is not the final one");

    a_marks_idle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE |-> (marks_reg == '0 && done_reg == '0))
        else $error("cascade marks left set while idle");

    a_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
        we |-> state_reg != S_IDLE)
        else $error("table written while idle");

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && (cmd.operation == OP_INSERT || cmd.operation == OP_DELETE
        || cmd.operation == OP_CASCADE || cmd.operation == OP_FIND
        || cmd.operation == OP_LIST) |=> busy)
        else $error("accepted command did not start");

endmodule

FILE: hdl/ptk_ram.sv
// Generic single write port RAM with registered read.
module ptk_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: tb/tb_parent_keyed_table.sv
// Self-checking testbench for the parent keyed table: directed and random commands.
module tb_parent_keyed_table;
    import ptk_pkg::*;

    localparam int WATCHDOG = 100000;

    // codes outside the defined operations, which the block ignores
    localparam logic [2:0] OP_SPARE_LO = 3'd5;
    localparam logic [2:0] OP_SPARE_HI = 3'd7;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    cmd_t cmd;
    logic valid;
    res_t result;

    // predictor state
    logic [KEY_W-1:0]  tbl_key [CAPACITY];
    logic [KEY_W-1:0]  tbl_par [CAPACITY];
    logic [INFO_W-1:0] tbl_info [CAPACITY];
    int                tbl_cnt;

    res_t expected_words[$];
    int   mismatches;
    int   words_seen;
    int   cmds_sent;
    int   idle_cycles;
    int   send_gap_pct;
    logic [KEY_W-1:0] key_pool[$];

    parent_keyed_table uut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .cmd(cmd), .valid(valid), .result(result)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic int find_index(logic [KEY_W-1:0] k);
        for (int i = 0; i < tbl_cnt; i++)
            if (tbl_key[i] == k) return i;
        return -1;
    endfunction

    function automatic res_t mk_word(logic [2:0] st, logic [KEY_W-1:0] k,
                                     logic [KEY_W-1:0] p, logic [INFO_W-1:0] inf,
                                     logic lst);
        res_t r;
        r.status = st; r.found_key = k; r.found_parent = p;
        r.found_info = inf; r.last = lst;
        return r;
    endfunction

    task automatic predict_table(cmd_t c);
        int idx;
        int n;
        int w;
        bit changed;
        bit hit;
        bit doomed [CAPACITY];
        res_t r;
        case (c.operation)
            OP_INSERT:
            begin
                if (find_index(c.item_key) >= 0)
                    expected_words.push_back(mk_word(ST_DUP, '0, '0, '0, 1'b1));
                else if (c.parent_key != '0 && c.parent_key != c.item_key
                         && find_index(c.parent_key) < 0)
                    expected_words.push_back(mk_word(ST_NOPAR, '0, '0, '0, 1'b1));
                else if (tbl_cnt >= CAPACITY)
                    expected_words.push_back(mk_word(ST_FULL, '0, '0, '0, 1'b1));
                else
                begin
                    tbl_key[tbl_cnt] = c.item_key;
                    tbl_par[tbl_cnt] = c.parent_key;
                    tbl_info[tbl_cnt] = c.info_word;
                    tbl_cnt++;
                    expected_words.push_back(mk_word(ST_OK, '0, '0, '0, 1'b1));
                end
            end
            OP_DELETE:
            begin
                idx = find_index(c.item_key);
                if (idx < 0)
                    expected_words.push_back(mk_word(ST_NOTFOUND, '0, '0, '0, 1'b1));
                else
                begin
                    for (int i = idx; i + 1 < tbl_cnt; i++)
                    begin
                        tbl_key[i] = tbl_key[i+1];
                        tbl_par[i] = tbl_par[i+1];
                        tbl_info[i] = tbl_info[i+1];
                    end
                    tbl_cnt--;
                    expected_words.push_back(mk_word(ST_OK, '0, '0, '0, 1'b1));
                end
            end
            OP_CASCADE:
            begin
                for (int i = 0; i < CAPACITY; i++) doomed[i] = 0;
                changed = 1;
                while (changed)
                begin
                    changed = 0;
                    for (int i = 0; i < tbl_cnt; i++)
                    begin
                        if (doomed[i] || tbl_par[i] == tbl_key[i]) continue;
                        hit = (tbl_par[i] == c.item_key);
                        for (int j = 0; !hit && j < tbl_cnt; j++)
                            if (doomed[j] && tbl_key[j] == tbl_par[i]) hit = 1;
                        if (hit)
                        begin
                            doomed[i] = 1;
                            changed = 1;
                        end
                    end
                end
                w = 0;
                for (int i = 0; i < tbl_cnt; i++)
                begin
                    if (doomed[i] || tbl_key[i] == c.item_key) continue;
                    tbl_key[w] = tbl_key[i];
                    tbl_par[w] = tbl_par[i];
                    tbl_info[w] = tbl_info[i];
                    w++;
                end
                tbl_cnt = w;
                expected_words.push_back(mk_word(ST_OK, '0, '0, '0, 1'b1));
            end
            OP_FIND:
            begin
                idx = find_index(c.item_key);
                if (idx < 0)
                    expected_words.push_back(mk_word(ST_NOTFOUND, '0, '0, '0, 1'b1));
                else
                    expected_words.push_back(mk_word(ST_OK, tbl_key[idx],
                                             tbl_par[idx], tbl_info[idx], 1'b1));
            end
            OP_LIST:
            begin
                n = 0;
                for (int i = tbl_cnt; i > 0; i--)
                begin
                    if (tbl_par[i-1] != c.parent_key) continue;
                    expected_words.push_back(mk_word(ST_OK, tbl_key[i-1],
                                             tbl_par[i-1], tbl_info[i-1], 1'b0));
                    n++;
                end
                if (n == 0)
                    expected_words.push_back(mk_word(ST_NOTFOUND, '0, '0, '0, 1'b1));
                else
                begin
                    r = expected_words.pop_back();
                    r.last = 1'b1;
                    expected_words.push_back(r);
                end
            end
            default: ;
        endcase
    endtask

    // result checker; the receiver cannot stall so every strobe is taken
    always @(posedge clk)
    begin
        if (rst_n && valid)
        begin
            words_seen++;
            if (expected_words.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: %p", result);
            end
            else
            begin
                res_t e;
                e = expected_words.pop_front();
                if (e.status !== result.status || e.found_key !== result.found_key
                    || e.found_parent !== result.found_parent
                    || e.found_info !== result.found_info || e.last !== result.last)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p got %p", e, result);
                end
            end
        end
    end

    // watchdog on cycles with nothing accepted
    always @(posedge clk)
    begin
        if (rst_n && !(valid || (start && !busy)))
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG)
            begin
                $display("watchdog expired");
                $display("end of test: mismatches");
                $finish;
            end
        end
        else
            idle_cycles <= 0;
    end

    // start stays high into the next command when no gap is drawn
    task automatic send_cmd(logic [2:0] op, logic [KEY_W-1:0] k,
                            logic [KEY_W-1:0] p, logic [INFO_W-1:0] inf);
        cmd_t c;
        c.operation = op; c.item_key = k; c.parent_key = p; c.info_word = inf;
        if ($urandom_range(99) < send_gap_pct)
        begin
            start <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_gap_pct);
        end
        start <= 1'b1;
        cmd <= c;
        @(posedge clk);
        while (busy) @(posedge clk);
        predict_table(c);
        cmds_sent++;
    endtask

    task automatic drain;
        start <= 1'b0;
        while (expected_words.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic test_directed;
        send_cmd(OP_FIND, 32'hFFFF_FFFF, '0, '0);
        send_cmd(OP_LIST, '0, '0, '0);
        send_cmd(OP_INSERT, 32'd1, '0, 32'hFFFF_FFFF);
        send_cmd(OP_INSERT, 32'd1, '0, '0);                // duplicate
        send_cmd(OP_INSERT, 32'd2, 32'd99, '0);            // absent parent
        send_cmd(OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h5A5A_A5A5); // own parent
        send_cmd(OP_INSERT, 32'd2, 32'd1, 32'd22);
        send_cmd(OP_INSERT, 32'd3, 32'd1, 32'd33);
        send_cmd(OP_INSERT, 32'd4, 32'd3, 32'd44);
        send_cmd(OP_LIST, '0, 32'd1, '0);
        send_cmd(OP_FIND, 32'd3, '0, '0);
        send_cmd(OP_DELETE, 32'd77, '0, '0);
        send_cmd(OP_DELETE, 32'd2, '0, '0);
        send_cmd(OP_SPARE_LO, 32'd1, '0, '0);              // ignored codes
        send_cmd(OP_SPARE_HI, 32'd1, '0, '0);
        send_cmd(OP_CASCADE, 32'd1, '0, '0);               // chain, key present
        send_cmd(OP_LIST, '0, 32'd1, '0);
        send_cmd(OP_CASCADE, 32'hFFFF_FFFF, '0, '0);       // self-parented root
        send_cmd(OP_INSERT, 32'd10, '0, '0);
        send_cmd(OP_INSERT, 32'd11, 32'd10, '0);
        send_cmd(OP_CASCADE, 32'd50, '0, '0);              // nothing removed
        send_cmd(OP_CASCADE, 32'd10, '0, '0);
        drain();
    endtask

    task automatic test_fill;
        // table to capacity, then full, list with many children, cascade all
        send_cmd(OP_INSERT, 32'd1000, '0, '0);
        for (int i = 1; i <= CAPACITY; i++)
            send_cmd(OP_INSERT, 32'd1000 + i, 32'd1000, $urandom);
        send_cmd(OP_INSERT, 32'd5, '0, '0);
        send_cmd(OP_LIST, '0, 32'd1000, '0);
        send_cmd(OP_CASCADE, 32'd1000, '0, '0);
        drain();
    endtask

    function automatic logic [KEY_W-1:0] pick_key();
        if (key_pool.size() != 0 && $urandom_range(9) < 8)
            return key_pool[$urandom_range(key_pool.size() - 1)];
        return ($urandom_range(1) != 0) ? $urandom : $urandom_range(40);
    endfunction

    task automatic test_random(int count, int gap);
        logic [2:0] op;
        logic [KEY_W-1:0] k;
        logic [KEY_W-1:0] p;
        int sel;
        send_gap_pct = gap;
        for (int n = 0; n < count; n++)
        begin
            sel = $urandom_range(99);
            if (sel < 45) op = OP_INSERT;
            else if (sel < 55) op = OP_DELETE;
            else if (sel < 62) op = OP_CASCADE;
            else if (sel < 78) op = OP_FIND;
            else if (sel < 97) op = OP_LIST;
            else op = 3'($urandom_range(7, 5));
            k = pick_key();
            sel = $urandom_range(9);
            p = (sel < 2) ? '0 : (sel < 3) ? k : pick_key();
            if (op == OP_INSERT) key_pool.push_back(k);
            if (key_pool.size() > 24) void'(key_pool.pop_front());
            send_cmd(op, k, p, $urandom);
        end
        drain();
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        cmd = '0;
        tbl_cnt = 0;
        mismatches = 0;
        words_seen = 0;
        cmds_sent = 0;
        idle_cycles = 0;
        send_gap_pct = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        send_gap_pct = 82;
        test_fill();
        test_random(60, 0);
        test_random(50, 82);
        test_random(60, 14);
        $display("%0d commands sent, %0d result words checked across idle mixes",
                 cmds_sent, words_seen);
        if (mismatches == 0 && expected_words.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule
